// ----- hw/rtl/tdp_pkg.sv -----
// Package: shared constants and control types for the trial-division prime tester.
`timescale 1ns / 1ps
package tdp_pkg;

    localparam int NUMBER_BITS_DEF = 16;
    localparam int CAND_BITS       = 16;
    localparam int FIRST_DIVISOR   = 2;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_div_sts;

endpackage

// ----- hw/rtl/tdp_if.sv -----
// Interfaces: candidate and result channels with valid/ready handshake.
`timescale 1ns / 1ps
interface tdp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface tdp_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] tested_number;
    logic        is_prime;

    modport source (output valid, output tested_number, output is_prime, input ready);
    modport sink   (input valid, input tested_number, input is_prime, output ready);
endinterface

// ----- hw/rtl/tdp_div.sv -----
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps
module tdp_div #(
    parameter int NUMBER_BITS = tdp_pkg::NUMBER_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tdp_pkg::t_div_ctl      i_ctl,
    input  logic [NUMBER_BITS-1:0] i_dividend,
    input  logic [NUMBER_BITS-1:0] i_divisor,
    output tdp_pkg::t_div_sts      o_sts
);
    import tdp_pkg::*;

    localparam int CNT_BITS = (NUMBER_BITS > 1) ? $clog2(NUMBER_BITS) : 1;

    logic                   r_busy;
    logic                   r_done;
    logic                   r_rem_zero;
    logic [CNT_BITS-1:0]    r_cnt;
    logic [NUMBER_BITS-1:0] r_rem;
    logic [NUMBER_BITS-1:0] r_shift;

    logic [NUMBER_BITS:0]   w_trial;
    logic [NUMBER_BITS:0]   w_next;

    assign w_trial = {r_rem, r_shift[NUMBER_BITS-1]};
    assign w_next  = (w_trial >= {1'b0, i_divisor}) ? (w_trial - {1'b0, i_divisor}) : w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_done     <= 1'b0;
            r_rem_zero <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(NUMBER_BITS - 1)) begin
                    r_busy     <= 1'b0;
                    r_done     <= 1'b1;
                    r_rem_zero <= (w_next == '0);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem   <= '0;
            r_shift <= i_dividend;
        end else if (r_busy) begin
            r_rem   <= w_next[NUMBER_BITS-1:0];
            r_shift <= {r_shift[NUMBER_BITS-2:0], 1'b0};
        end
    end

    assign o_sts.done     = r_done;
    assign o_sts.rem_zero = r_rem_zero;

endmodule

// ----- hw/rtl/trial_division_prime_test.sv -----
// Top level: trial-division primality tester with registered result channel.
//
// Usage:
//   i_in carries one candidate per item; o_out returns one result per item,
//   the candidate (masked to NUMBER_BITS) and an is_prime flag.
//   Divisors are tried from 2 upward while divisor squared does not exceed the
//   candidate; the search stops at the first divisor with zero remainder.
//   Each trial checks the square bound in ST_CHECK, then runs the bit-serial
//   remainder unit in ST_DIV and takes its verdict there. Candidates 0 and 1
//   go straight to ST_DONE; 2 and 3 fail the square bound at once and
//   finish without a trial.
//   A new candidate is taken only after the previous search has finished.
//   The result sits in an output register: a new candidate is accepted while
//   it waits, but that search's result holds until the receiver takes the old
//   one. Reset clears the control state and drops any pending result.
`timescale 1ns / 1ps
module trial_division_prime_test #(
    parameter int NUMBER_BITS = tdp_pkg::NUMBER_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tdp_in_if.sink    i_in,
    tdp_out_if.source o_out
);
    import tdp_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic [NUMBER_BITS-1:0] r_n;
    logic [NUMBER_BITS-1:0] r_d;
    logic [NUMBER_BITS:0]   r_sq;
    logic                   r_prime;
    logic                   r_out_valid;
    logic [15:0]            r_out_num;
    logic                   r_out_prime;

    logic [NUMBER_BITS-1:0] w_cand;
    logic [15:0]            w_num16;
    logic                   w_accept;
    logic                   w_load;
    t_div_ctl               w_ctl;
    t_div_sts               w_sts;

    generate
        if (NUMBER_BITS > CAND_BITS) begin : g_wide
            assign w_cand  = {{(NUMBER_BITS - CAND_BITS){1'b0}}, i_in.candidate};
            assign w_num16 = r_n[CAND_BITS-1:0];
        end else if (NUMBER_BITS == CAND_BITS) begin : g_equal
            assign w_cand  = i_in.candidate;
            assign w_num16 = r_n;
        end else begin : g_narrow
            assign w_cand  = i_in.candidate[NUMBER_BITS-1:0];
            assign w_num16 = {{(CAND_BITS - NUMBER_BITS){1'b0}}, r_n};
        end
    endgenerate

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_load     = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);
    assign w_ctl.start = (r_state == ST_CHECK) && !(r_sq > {1'b0, r_n});

    tdp_div #(
        .NUMBER_BITS(NUMBER_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_dividend(r_n),
        .i_divisor (r_d),
        .o_sts     (w_sts)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (w_cand < NUMBER_BITS'(FIRST_DIVISOR)) ? ST_DONE : ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = w_ctl.start ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                if (w_sts.done) begin
                    n_state = w_sts.rem_zero ? ST_DONE : ST_CHECK;
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_n     <= w_cand;
            r_d     <= NUMBER_BITS'(FIRST_DIVISOR);
            r_sq    <= (NUMBER_BITS + 1)'(FIRST_DIVISOR * FIRST_DIVISOR);
            r_prime <= 1'b0;
        end else if (r_state == ST_CHECK && !w_ctl.start) begin
            r_prime <= 1'b1;
        end else if (r_state == ST_DIV && w_sts.done) begin
            if (w_sts.rem_zero) begin
                r_prime <= 1'b0;
            end else begin
                r_sq <= r_sq + {r_d, 1'b1};
                r_d  <= r_d + 1'b1;
            end
        end
        if (w_load) begin
            r_out_num   <= w_num16;
            r_out_prime <= r_prime;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.tested_number = r_out_num;
    assign o_out.is_prime      = r_out_prime;

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> (r_state == ST_DIV))
        else $error("remainder unit finished outside a trial");

    a_prime_ge_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_prime) |-> (r_n >= NUMBER_BITS'(FIRST_DIVISOR)))
        else $error("number below two reported prime");

    a_square_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_sq <= {1'b0, r_n}))
        else $error("trial divisor beyond square root");

    a_divisor_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK || r_state == ST_DIV) |-> (r_d >= NUMBER_BITS'(FIRST_DIVISOR)))
        else $error("trial divisor below two");

    a_load_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_num)))
        else $error("pending result overwritten");

endmodule
